@@ hdl/ffca_pkg.sv @@
// ----------------------------------------------------------------------------
// First-fit coalescing allocator package
// Shared types, codes and default sizes for the allocator controller,
// datapath and top level.
// ----------------------------------------------------------------------------
`default_nettype none

package ffca_pkg;

  localparam int POOL_DEPTH_DEF   = 512;
  localparam int HASH_BUCKETS_DEF = 1024;
  localparam int WORD_BYTES_DEF   = 4;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_ADD   = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NULL     = 3'd1,
    ST_NOSPACE  = 3'd2,
    ST_NODESC   = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  typedef enum logic [4:0] {
    C_NOP,
    C_CLR,
    C_LOAD,
    C_A_INIT,
    C_RD,
    C_STEP,
    C_A_TAKE,
    C_SP_RD,
    C_SPLIT,
    C_A_HRD,
    C_A_FIN,
    C_F_INIT,
    C_F_HEAD,
    C_F_TAKE,
    C_U_CHK,
    C_M_BUCK,
    C_M_BOTH,
    C_UL_HI,
    C_UL_LO,
    C_UL_CHK,
    C_M_AREA_USE,
    C_M_LO_HI,
    C_M_HI_SPARE,
    C_M_LO_LEN,
    C_M_HI_BL,
    C_M_AREA_SPARE,
    C_ADD,
    C_FIN
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t op;
    status_t st;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       size_zero;
    logic       need_ovf;
    logic       addr_zero;
    logic       walk_end;
    logic       fits;
    logic       split;
    logic       spare_nil;
    logic       match;
    logic       both;
    logic       lo_v;
    logic       hi_v;
    logic       ul_hit;
    logic       clr_last;
    logic       out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

@@ hdl/ffca_ctrl.sv @@
// ----------------------------------------------------------------------------
// First-fit coalescing allocator controller
// Sequences the list walks and descriptor updates of each request and
// drives the datapath one command per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ffca_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire ffca_pkg::dp_stat_t stat,
  output ffca_pkg::dp_cmd_t       cmd
);
  import ffca_pkg::*;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_DISP,
    S_A_RD, S_A_CHK, S_A_SPR, S_A_SPLIT, S_A_HRD, S_A_FIN,
    S_F_HEAD, S_F_RD, S_F_CHK, S_U_RD, S_U_CHK,
    S_M_BUCK, S_M_BOTH, S_UL_HI, S_UL_LO, S_UL_RD, S_UL_CHK,
    S_M_AUSE, S_M_LOHI, S_M_HISP, S_M_LOLEN, S_M_HIBL, S_M_ASPR,
    S_ADD, S_FIN
  } state_t;

  state_t  state_r, state_nxt;
  status_t st_r, st_nxt;
  logic    second_r, second_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt  = state_r;
    st_nxt     = st_r;
    second_nxt = second_r;
    cmd        = '{op: C_NOP, st: st_r};
    unique case (state_r)
      S_CLR: begin
        cmd.op = C_CLR;
        if (stat.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.op     = C_LOAD;
          second_nxt = 1'b0;
          state_nxt  = S_DISP;
        end
      end
      S_DISP: begin
        unique case (stat.op)
          OP_ALLOC: begin
            if (stat.size_zero) begin
              st_nxt = ST_NULL; state_nxt = S_FIN;
            end else if (stat.need_ovf) begin
              st_nxt = ST_NOSPACE; state_nxt = S_FIN;
            end else begin
              cmd.op = C_A_INIT; state_nxt = S_A_RD;
            end
          end
          OP_FREE: begin
            if (stat.addr_zero) begin
              st_nxt = ST_NULL; state_nxt = S_FIN;
            end else begin
              cmd.op = C_F_INIT; state_nxt = S_F_HEAD;
            end
          end
          OP_ADD: begin
            if (stat.spare_nil) begin
              st_nxt = ST_NODESC; state_nxt = S_FIN;
            end else begin
              cmd.op = C_SP_RD; state_nxt = S_ADD;
            end
          end
          default: begin
            st_nxt = ST_NULL; state_nxt = S_FIN;
          end
        endcase
      end
      S_A_RD: begin
        if (stat.walk_end) begin
          st_nxt = ST_NOSPACE; state_nxt = S_FIN;
        end else begin
          cmd.op = C_RD; state_nxt = S_A_CHK;
        end
      end
      S_A_CHK: begin
        if (!stat.fits) begin
          cmd.op = C_STEP; state_nxt = S_A_RD;
        end else if (stat.split && stat.spare_nil) begin
          st_nxt = ST_NODESC; state_nxt = S_FIN;
        end else begin
          cmd.op    = C_A_TAKE;
          state_nxt = stat.split ? S_A_SPR : S_A_HRD;
        end
      end
      S_A_SPR: begin
        cmd.op = C_SP_RD; state_nxt = S_A_SPLIT;
      end
      S_A_SPLIT: begin
        cmd.op = C_SPLIT; state_nxt = S_A_HRD;
      end
      S_A_HRD: begin
        cmd.op = C_A_HRD; state_nxt = S_A_FIN;
      end
      S_A_FIN: begin
        cmd.op = C_A_FIN; st_nxt = ST_OK; state_nxt = S_FIN;
      end
      S_F_HEAD: begin
        cmd.op = C_F_HEAD; state_nxt = S_F_RD;
      end
      S_F_RD: begin
        if (stat.walk_end) begin
          st_nxt = ST_NOTFOUND; state_nxt = S_FIN;
        end else begin
          cmd.op = C_RD; state_nxt = S_F_CHK;
        end
      end
      S_F_CHK: begin
        if (stat.match) begin
          cmd.op = C_F_TAKE; state_nxt = S_U_RD;
        end else begin
          cmd.op = C_STEP; state_nxt = S_F_RD;
        end
      end
      S_U_RD: begin
        if (stat.walk_end) begin
          state_nxt = S_M_BUCK;
        end else begin
          cmd.op = C_RD; state_nxt = S_U_CHK;
        end
      end
      S_U_CHK: begin
        cmd.op    = C_U_CHK;
        state_nxt = stat.both ? S_M_BUCK : S_U_RD;
      end
      S_M_BUCK: begin
        cmd.op = C_M_BUCK;
        st_nxt = ST_OK;
        if (stat.lo_v && stat.hi_v) state_nxt = S_M_BOTH;
        else if (stat.lo_v)         state_nxt = S_M_LOLEN;
        else if (stat.hi_v)         state_nxt = S_M_HIBL;
        else                        state_nxt = S_M_AUSE;
      end
      S_M_BOTH: begin
        cmd.op = C_M_BOTH; state_nxt = S_UL_HI;
      end
      S_UL_HI: begin
        cmd.op = C_UL_HI; second_nxt = 1'b0; state_nxt = S_UL_RD;
      end
      S_UL_LO: begin
        cmd.op = C_UL_LO; second_nxt = 1'b1; state_nxt = S_UL_RD;
      end
      S_UL_RD: begin
        if (stat.walk_end) begin
          state_nxt = second_r ? S_M_AUSE : S_UL_LO;
        end else begin
          cmd.op = C_RD; state_nxt = S_UL_CHK;
        end
      end
      S_UL_CHK: begin
        cmd.op = C_UL_CHK;
        if (stat.ul_hit) state_nxt = second_r ? S_M_AUSE : S_UL_LO;
        else             state_nxt = S_UL_RD;
      end
      S_M_AUSE: begin
        cmd.op    = C_M_AREA_USE;
        state_nxt = second_r ? S_M_LOHI : S_FIN;
      end
      S_M_LOHI: begin
        cmd.op = C_M_LO_HI; state_nxt = S_M_HISP;
      end
      S_M_HISP: begin
        cmd.op = C_M_HI_SPARE; state_nxt = S_FIN;
      end
      S_M_LOLEN: begin
        cmd.op = C_M_LO_LEN; state_nxt = S_M_ASPR;
      end
      S_M_HIBL: begin
        cmd.op = C_M_HI_BL; state_nxt = S_M_ASPR;
      end
      S_M_ASPR: begin
        cmd.op = C_M_AREA_SPARE; state_nxt = S_FIN;
      end
      S_ADD: begin
        cmd.op = C_ADD; st_nxt = ST_OK; state_nxt = S_FIN;
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.op = C_FIN; state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLR;
      st_r     <= ST_OK;
      second_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      st_r     <= st_nxt;
      second_r <= second_nxt;
    end
  end

endmodule

`default_nettype wire

@@ hdl/ffca_dp.sv @@
// ----------------------------------------------------------------------------
// First-fit coalescing allocator datapath
// Descriptor and bucket memories, list walk registers, running totals and
// the result register, all driven by controller commands.
// ----------------------------------------------------------------------------
`default_nettype none

module ffca_dp #(
  parameter int POOL_DEPTH   = ffca_pkg::POOL_DEPTH_DEF,
  parameter int HASH_BUCKETS = ffca_pkg::HASH_BUCKETS_DEF,
  parameter int WORD_BYTES   = ffca_pkg::WORD_BYTES_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire ffca_pkg::dp_cmd_t cmd,
  input  wire logic [1:0]        in_opcode,
  input  wire logic [31:0]       in_address,
  input  wire logic [31:0]       in_size,
  input  wire logic              out_tready,
  output logic                   out_tvalid,
  output ffca_pkg::status_t      out_status,
  output logic [31:0]            out_granted_address,
  output logic [31:0]            out_granted_bytes,
  output logic [31:0]            out_free_bytes,
  output logic [31:0]            out_used_bytes,
  output logic [31:0]            out_added_bytes,
  output ffca_pkg::dp_stat_t     stat
);
  import ffca_pkg::*;

  localparam int PW    = $clog2(POOL_DEPTH + 1);
  localparam int PA    = $clog2(POOL_DEPTH);
  localparam int HA    = $clog2(HASH_BUCKETS);
  localparam int CLR_N = (POOL_DEPTH > HASH_BUCKETS) ? POOL_DEPTH : HASH_BUCKETS;
  localparam int CW    = $clog2(CLR_N);
  localparam int WL    = $clog2(WORD_BYTES);
  localparam logic [PW-1:0] NIL   = PW'(POOL_DEPTH);
  localparam logic [31:0]   GUARD = 32'(2 * WORD_BYTES);

  function automatic logic [HA-1:0] bucket_of(input logic [31:0] a);
    logic [31:0] h;
    h = a ^ (a >> 20) ^ (a >> 12);
    h = h ^ (h >> 7) ^ (h >> 4);
    return h[HA-1:0];
  endfunction

  logic [31:0]   base_mem [POOL_DEPTH];
  logic [31:0]   len_mem  [POOL_DEPTH];
  logic [PW-1:0] link_mem [POOL_DEPTH];
  logic [PW-1:0] bkt_mem  [HASH_BUCKETS];
  logic [31:0]   base_q, len_q;
  logic [PW-1:0] link_q, bkt_q;

  logic [1:0]    op_r;
  logic [31:0]   addr_r, size_r, begin_r, end_r;
  logic [33:0]   need_r;
  logic [PW-1:0] cur_r, prev_r, n_r, area_r, oprev_r, alink_r, lo_r, hi_r, t_r;
  logic [31:0]   cbase_r, clen_r, alen_r, lo_base_r, lo_len_r, hi_len_r;
  logic [HA-1:0] h_r;
  logic [31:0]   ga_r, gb_r;
  logic [PW-1:0] usable_r, spare_r;
  logic [31:0]   free_r, used_r, added_r;
  logic [CW-1:0] clr_r;
  logic          out_valid_r;

  logic [33:0]   rnd, need_in;
  logic [32:0]   added_sum;
  logic [PW-1:0] lo_n, hi_n;
  logic          lo_hit, hi_hit, both;
  logic [PW-1:0] pr_idx, pw_idx;
  logic          pw_base_en, pw_len_en, pw_link_en;
  logic [31:0]   pw_base, pw_len;
  logic [PW-1:0] pw_link;
  logic [HA-1:0] br_addr, bw_addr;
  logic          bw_en;
  logic [PW-1:0] bw_data;
  logic [31:0]   free_begin;

  assign rnd        = {2'b00, in_size} + 34'(WORD_BYTES - 1);
  assign need_in    = {rnd[33:WL], {WL{1'b0}}} + 34'(3 * WORD_BYTES);
  assign added_sum  = {1'b0, added_r} + {1'b0, size_r};
  assign free_begin = addr_r - GUARD;

  assign lo_hit = (base_q + len_q) == begin_r;
  assign hi_hit = base_q == end_r;
  assign lo_n   = lo_hit ? cur_r : lo_r;
  assign hi_n   = hi_hit ? cur_r : hi_r;
  assign both   = (lo_n < NIL) && (hi_n < NIL);

  always_comb begin
    stat.op        = op_r;
    stat.size_zero = (size_r == 32'd0);
    stat.need_ovf  = (need_r[33:32] != 2'b00);
    stat.addr_zero = (addr_r == 32'd0);
    stat.walk_end  = (cur_r >= NIL) || (n_r >= NIL);
    stat.fits      = {2'b00, len_q} >= need_r;
    stat.split     = need_r < {2'b00, len_q};
    stat.spare_nil = (spare_r >= NIL);
    stat.match     = (base_q == begin_r);
    stat.both      = both;
    stat.lo_v      = (lo_r < NIL);
    stat.hi_v      = (hi_r < NIL) && (hi_r != lo_r);
    stat.ul_hit    = (cur_r == t_r);
    stat.clr_last  = (clr_r == CW'(CLR_N - 1));
    stat.out_free  = !out_valid_r || out_tready;
  end

  always_comb begin
    pr_idx     = ((cmd.op == C_SP_RD) || (cmd.op == C_ADD)) ? spare_r : cur_r;
    br_addr    = (cmd.op == C_A_HRD) ? bucket_of(cbase_r) : bucket_of(free_begin);
    pw_idx     = cur_r;
    pw_base_en = 1'b0;
    pw_len_en  = 1'b0;
    pw_link_en = 1'b0;
    pw_base    = base_q;
    pw_len     = len_q;
    pw_link    = link_q;
    bw_en      = 1'b0;
    bw_addr    = h_r;
    bw_data    = cur_r;
    case (cmd.op)
      C_CLR: begin
        pw_idx     = PW'(clr_r);
        pw_link    = PW'(32'(clr_r) + 32'd1);
        pw_link_en = (32'(clr_r) < POOL_DEPTH);
        bw_addr    = clr_r[HA-1:0];
        bw_data    = NIL;
        bw_en      = (32'(clr_r) < HASH_BUCKETS);
      end
      C_A_TAKE: begin
        pw_idx     = prev_r;
        pw_link_en = (prev_r != NIL);
      end
      C_SPLIT: begin
        pw_idx     = spare_r;
        pw_base    = cbase_r + need_r[31:0];
        pw_len     = clen_r - need_r[31:0];
        pw_link    = usable_r;
        pw_base_en = 1'b1;
        pw_len_en  = 1'b1;
        pw_link_en = 1'b1;
      end
      C_A_FIN: begin
        pw_idx     = cur_r;
        pw_link    = bkt_q;
        pw_len     = need_r[31:0];
        pw_link_en = 1'b1;
        pw_len_en  = 1'b1;
        bw_en      = 1'b1;
        bw_data    = cur_r;
      end
      C_M_BUCK: begin
        pw_idx     = oprev_r;
        pw_link    = alink_r;
        pw_link_en = (oprev_r != NIL);
        bw_en      = (oprev_r == NIL);
        bw_data    = alink_r;
      end
      C_M_BOTH: begin
        pw_idx     = area_r;
        pw_base    = lo_base_r;
        pw_len     = alen_r + lo_len_r + hi_len_r;
        pw_base_en = 1'b1;
        pw_len_en  = 1'b1;
      end
      C_UL_CHK: begin
        pw_idx     = prev_r;
        pw_link_en = (cur_r == t_r) && (prev_r != NIL);
      end
      C_M_AREA_USE: begin
        pw_idx     = area_r;
        pw_link    = usable_r;
        pw_link_en = 1'b1;
      end
      C_M_LO_HI: begin
        pw_idx     = lo_r;
        pw_link    = hi_r;
        pw_link_en = 1'b1;
      end
      C_M_HI_SPARE: begin
        pw_idx     = hi_r;
        pw_link    = spare_r;
        pw_link_en = 1'b1;
      end
      C_M_LO_LEN: begin
        pw_idx    = lo_r;
        pw_len    = lo_len_r + alen_r;
        pw_len_en = 1'b1;
      end
      C_M_HI_BL: begin
        pw_idx     = hi_r;
        pw_base    = begin_r;
        pw_len     = hi_len_r + alen_r;
        pw_base_en = 1'b1;
        pw_len_en  = 1'b1;
      end
      C_M_AREA_SPARE: begin
        pw_idx     = area_r;
        pw_link    = spare_r;
        pw_link_en = 1'b1;
      end
      C_ADD: begin
        pw_idx     = spare_r;
        pw_base    = addr_r;
        pw_len     = size_r;
        pw_link    = usable_r;
        pw_base_en = 1'b1;
        pw_len_en  = 1'b1;
        pw_link_en = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (pw_base_en) base_mem[pw_idx[PA-1:0]] <= pw_base;
    base_q <= base_mem[pr_idx[PA-1:0]];
  end

  always_ff @(posedge clk) begin
    if (pw_len_en) len_mem[pw_idx[PA-1:0]] <= pw_len;
    len_q <= len_mem[pr_idx[PA-1:0]];
  end

  always_ff @(posedge clk) begin
    if (pw_link_en) link_mem[pw_idx[PA-1:0]] <= pw_link;
    link_q <= link_mem[pr_idx[PA-1:0]];
  end

  always_ff @(posedge clk) begin
    if (bw_en) bkt_mem[bw_addr] <= bw_data;
    bkt_q <= bkt_mem[br_addr];
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      C_LOAD: begin
        op_r   <= in_opcode;
        addr_r <= in_address;
        size_r <= in_size;
        need_r <= need_in;
        ga_r   <= 32'd0;
        gb_r   <= 32'd0;
      end
      C_A_INIT: begin
        cur_r  <= usable_r;
        prev_r <= NIL;
        n_r    <= '0;
      end
      C_STEP: begin
        prev_r <= cur_r;
        cur_r  <= link_q;
        n_r    <= n_r + 1'b1;
      end
      C_A_TAKE: begin
        cbase_r <= base_q;
        clen_r  <= len_q;
      end
      C_A_HRD: h_r <= bucket_of(cbase_r);
      C_A_FIN: begin
        ga_r <= cbase_r + GUARD;
        gb_r <= need_r[31:0];
      end
      C_F_INIT: begin
        begin_r <= free_begin;
        h_r     <= bucket_of(free_begin);
      end
      C_F_HEAD: begin
        cur_r  <= bkt_q;
        prev_r <= NIL;
        n_r    <= '0;
      end
      C_F_TAKE: begin
        area_r  <= cur_r;
        oprev_r <= prev_r;
        alen_r  <= len_q;
        alink_r <= link_q;
        end_r   <= begin_r + len_q;
        cur_r   <= usable_r;
        n_r     <= '0;
        lo_r    <= NIL;
        hi_r    <= NIL;
      end
      C_U_CHK: begin
        lo_r <= lo_n;
        hi_r <= hi_n;
        if (lo_hit) begin
          lo_base_r <= base_q;
          lo_len_r  <= len_q;
        end
        if (hi_hit) hi_len_r <= len_q;
        if (!both) begin
          cur_r <= link_q;
          n_r   <= n_r + 1'b1;
        end
      end
      C_M_BUCK: begin
        if (hi_r == lo_r) hi_r <= NIL;
        gb_r <= alen_r;
      end
      C_UL_HI, C_UL_LO: begin
        t_r    <= (cmd.op == C_UL_HI) ? hi_r : lo_r;
        prev_r <= NIL;
        cur_r  <= usable_r;
        n_r    <= '0;
      end
      C_UL_CHK: begin
        if (cur_r != t_r) begin
          prev_r <= cur_r;
          cur_r  <= link_q;
          n_r    <= n_r + 1'b1;
        end
      end
      C_ADD: gb_r <= size_r;
      C_FIN: begin
        out_status          <= cmd.st;
        out_granted_address <= (cmd.st == ST_OK) ? ga_r : 32'd0;
        out_granted_bytes   <= (cmd.st == ST_OK) ? gb_r : 32'd0;
        out_free_bytes      <= free_r;
        out_used_bytes      <= used_r;
        out_added_bytes     <= added_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      usable_r    <= NIL;
      spare_r     <= '0;
      free_r      <= 32'd0;
      used_r      <= 32'd0;
      added_r     <= 32'd0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.op == C_FIN)  out_valid_r <= 1'b1;
      else if (out_tready)  out_valid_r <= 1'b0;
      case (cmd.op)
        C_CLR:    clr_r <= clr_r + 1'b1;
        C_A_TAKE: if (prev_r == NIL) usable_r <= link_q;
        C_SPLIT: begin
          spare_r  <= link_q;
          usable_r <= spare_r;
        end
        C_A_FIN: begin
          free_r <= free_r - need_r[31:0];
          used_r <= used_r + need_r[31:0];
        end
        C_M_BUCK: begin
          used_r <= used_r - alen_r;
          free_r <= free_r + alen_r;
        end
        C_UL_CHK:       if ((cur_r == t_r) && (prev_r == NIL)) usable_r <= link_q;
        C_M_AREA_USE:   usable_r <= area_r;
        C_M_HI_SPARE:   spare_r  <= lo_r;
        C_M_AREA_SPARE: spare_r  <= area_r;
        C_ADD: begin
          spare_r  <= link_q;
          usable_r <= spare_r;
          free_r   <= free_r + size_r;
          added_r  <= added_sum[32] ? 32'hFFFF_FFFF : added_sum[31:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

`default_nettype wire

@@ hdl/first_fit_coalescing_allocator.sv @@
// ----------------------------------------------------------------------------
// First-fit coalescing allocator
// Heap allocator over a pool of region descriptors with first-fit allocate,
// release with neighbor merging, and region add.
// ----------------------------------------------------------------------------
//  Channel | Direction | Contents
//  in_     | request   | opcode, address, size
//  out_    | result    | status, granted address and bytes, free/used/added
//
//  Allocate walks the usable list and takes a spare descriptor when the
//  region is split. Release walks the bucket chain and then the usable
//  list; a merge with both neighbors adds two more usable list walks.
//  The base, length and link memories share one read index.
//  After reset a clearing pass over every descriptor link and bucket entry runs
//  before the first request is taken. A result waits in the output register
//  and the next request is taken while it does; that request's result stalls
//  until the waiting one has been taken.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_coalescing_allocator #(
  parameter int POOL_DEPTH   = ffca_pkg::POOL_DEPTH_DEF,
  parameter int HASH_BUCKETS = ffca_pkg::HASH_BUCKETS_DEF,
  parameter int WORD_BYTES   = ffca_pkg::WORD_BYTES_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [71:0]  in_tdata,   // opcode[1:0], address[33:2], size[65:34]
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [167:0]      out_tdata   // status[2:0], granted_address[34:3],
                                        // granted_bytes[66:35], free_bytes[98:67],
                                        // used_bytes[130:99], added_bytes[162:131]
);
  import ffca_pkg::*;

  dp_cmd_t     cmd;
  dp_stat_t    stat;
  status_t     status;
  logic [31:0] ga, gb, fb, ub, ab;

  ffca_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ffca_dp #(
    .POOL_DEPTH   (POOL_DEPTH),
    .HASH_BUCKETS (HASH_BUCKETS),
    .WORD_BYTES   (WORD_BYTES)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .in_opcode           (in_tdata[1:0]),
    .in_address          (in_tdata[33:2]),
    .in_size             (in_tdata[65:34]),
    .out_tready          (out_tready),
    .out_tvalid          (out_tvalid),
    .out_status          (status),
    .out_granted_address (ga),
    .out_granted_bytes   (gb),
    .out_free_bytes      (fb),
    .out_used_bytes      (ub),
    .out_added_bytes     (ab),
    .stat                (stat)
  );

  assign out_tdata = {5'd0, ab, ub, fb, gb, ga, status};

`ifndef SYNTHESIS
  a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request accepted while another is in progress");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[2:0] <= 3'd4)
    else $error("result status out of range");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[2:0] != ST_OK) |-> out_tdata[66:3] == 64'd0)
    else $error("failed request reports granted address or bytes");

  a_null_addr: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) && (out_tdata[34:3] != 32'd0) |-> out_tdata[2:0] == ST_OK)
    else $error("granted address without ok status");
`endif

endmodule

`default_nettype wire

@@ tb/sv/tb_first_fit_coalescing_allocator.sv @@
// ----------------------------------------------------------------------------
// First-fit coalescing allocator testbench
// Drives allocate, release, add and unused-opcode requests into the allocator. It predicts
// each result with its own model of the descriptor pool, the usable list, the
// spare list and the occupied hash chains, and compares the results field by
// field. The random release requests mostly name pointers that are still
// live, under three idle patterns.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_first_fit_coalescing_allocator;
  timeunit 1ns;
  timeprecision 1ps;
  import ffca_pkg::*;

  localparam int DEPTH   = POOL_DEPTH_DEF;
  localparam int BUCKETS = HASH_BUCKETS_DEF;
  localparam int WB      = WORD_BYTES_DEF;
  localparam logic [9:0] NIL = 10'(DEPTH);
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 40000;

  typedef struct {
    logic [1:0]  opcode;
    logic [31:0] address;
    logic [31:0] size;
    int          tx_idle;
    int          rx_idle;
  } request_t;

  typedef struct {
    status_t     status;
    logic [31:0] granted_address;
    logic [31:0] granted_bytes;
    logic [31:0] free_bytes;
    logic [31:0] used_bytes;
    logic [31:0] added_bytes;
  } grant_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [71:0]  in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [167:0] out_tdata;

  request_t    pending_requests[$];
  grant_t      expected_grants[$];
  logic [31:0] live_pointers[$];
  int          errors = 0;
  int          tx_idle_pct = 27;
  int          rx_idle_pct = 69;
  int          quiet_cycles = 0;
  logic [31:0] next_base = 32'h0001_0000;

  logic [31:0] mdl_base[DEPTH];
  logic [31:0] mdl_len[DEPTH];
  logic [9:0]  mdl_link[DEPTH];
  logic [9:0]  mdl_bucket[BUCKETS];
  logic [9:0]  mdl_usable;
  logic [9:0]  mdl_spare;
  logic [31:0] mdl_free;
  logic [31:0] mdl_used;
  logic [31:0] mdl_added;

  first_fit_coalescing_allocator dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always #10 clk = ~clk;

  function automatic logic [9:0] hash_bucket(input logic [31:0] a);
    logic [31:0] h;
    h = a;
    h = h ^ (h >> 20) ^ (h >> 12);
    h = h ^ (h >> 7) ^ (h >> 4);
    return h[9:0];
  endfunction

  function automatic void drop_usable(input logic [9:0] d);
    logic [9:0] prev;
    logic [9:0] cur;
    prev = NIL;
    cur = mdl_usable;
    for (int n = 0; cur < NIL && n < DEPTH; n++) begin
      if (cur == d) begin
        if (prev == NIL) mdl_usable = mdl_link[cur];
        else mdl_link[prev] = mdl_link[cur];
        return;
      end
      prev = cur;
      cur = mdl_link[cur];
    end
  endfunction

  function automatic status_t model_alloc(input logic [31:0] size, output logic [31:0] ga,
                                          output logic [31:0] gb);
    logic [33:0] need;
    logic [9:0]  prev;
    logic [9:0]  cur;
    logic [9:0]  nd;
    logic [9:0]  h;
    int          n;
    ga = '0;
    gb = '0;
    if (size == 0) return ST_NULL;
    need = (((34'(size) + WB - 1) / WB) * WB) + 3 * WB;
    if (need > 34'hFFFF_FFFF) return ST_NOSPACE;
    prev = NIL;
    cur = mdl_usable;
    for (n = 0; cur < NIL && n < DEPTH; n++) begin
      if (34'(mdl_len[cur]) >= need) break;
      prev = cur;
      cur = mdl_link[cur];
    end
    if (cur >= NIL || n >= DEPTH) return ST_NOSPACE;
    if (need < 34'(mdl_len[cur]) && mdl_spare >= NIL) return ST_NODESC;
    if (prev == NIL) mdl_usable = mdl_link[cur];
    else mdl_link[prev] = mdl_link[cur];
    if (need < 34'(mdl_len[cur])) begin
      nd = mdl_spare;
      mdl_spare = mdl_link[nd];
      mdl_base[nd] = mdl_base[cur] + need[31:0];
      mdl_len[nd] = mdl_len[cur] - need[31:0];
      mdl_len[cur] = need[31:0];
      mdl_link[nd] = mdl_usable;
      mdl_usable = nd;
    end
    h = hash_bucket(mdl_base[cur]);
    mdl_link[cur] = mdl_bucket[h];
    mdl_bucket[h] = cur;
    mdl_free = mdl_free - need[31:0];
    mdl_used = mdl_used + need[31:0];
    ga = mdl_base[cur] + 2 * WB;
    gb = need[31:0];
    return ST_OK;
  endfunction

  function automatic status_t model_release(input logic [31:0] addr, output logic [31:0] gb);
    logic [31:0] begin_addr;
    logic [31:0] len;
    logic [31:0] end_addr;
    logic [9:0]  h;
    logic [9:0]  oprev;
    logic [9:0]  area;
    logic [9:0]  a;
    logic [9:0]  lo;
    logic [9:0]  hi;
    int          n;
    gb = '0;
    if (addr == 0) return ST_NULL;
    begin_addr = addr - 2 * WB;
    h = hash_bucket(begin_addr);
    oprev = NIL;
    area = mdl_bucket[h];
    for (n = 0; area < NIL && n < DEPTH; n++) begin
      if (mdl_base[area] == begin_addr) break;
      oprev = area;
      area = mdl_link[area];
    end
    if (area >= NIL || n >= DEPTH) return ST_NOTFOUND;
    len = mdl_len[area];
    end_addr = begin_addr + len;
    lo = NIL;
    hi = NIL;
    a = mdl_usable;
    for (n = 0; a < NIL && n < DEPTH; n++) begin
      if (mdl_base[a] + mdl_len[a] == begin_addr) lo = a;
      if (mdl_base[a] == end_addr) hi = a;
      if (lo < NIL && hi < NIL) break;
      a = mdl_link[a];
    end
    if (hi == lo) hi = NIL;
    if (oprev == NIL) mdl_bucket[h] = mdl_link[area];
    else mdl_link[oprev] = mdl_link[area];
    if (lo < NIL && hi < NIL) begin
      mdl_len[area] = len + mdl_len[lo] + mdl_len[hi];
      mdl_base[area] = mdl_base[lo];
      drop_usable(hi);
      drop_usable(lo);
      mdl_link[area] = mdl_usable;
      mdl_usable = area;
      mdl_link[lo] = hi;
      mdl_link[hi] = mdl_spare;
      mdl_spare = lo;
    end else if (lo < NIL) begin
      mdl_len[lo] = mdl_len[lo] + len;
      mdl_link[area] = mdl_spare;
      mdl_spare = area;
    end else if (hi < NIL) begin
      mdl_base[hi] = begin_addr;
      mdl_len[hi] = mdl_len[hi] + len;
      mdl_link[area] = mdl_spare;
      mdl_spare = area;
    end else begin
      mdl_link[area] = mdl_usable;
      mdl_usable = area;
    end
    mdl_used = mdl_used - len;
    mdl_free = mdl_free + len;
    gb = len;
    return ST_OK;
  endfunction

  function automatic status_t model_add(input logic [31:0] addr, input logic [31:0] size,
                                        output logic [31:0] gb);
    logic [9:0]  d;
    logic [32:0] sum;
    gb = '0;
    d = mdl_spare;
    if (d >= NIL) return ST_NODESC;
    mdl_spare = mdl_link[d];
    mdl_base[d] = addr;
    mdl_len[d] = size;
    mdl_link[d] = mdl_usable;
    mdl_usable = d;
    mdl_free = mdl_free + size;
    sum = 33'(mdl_added) + 33'(size);
    mdl_added = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    gb = size;
    return ST_OK;
  endfunction

  // Requests are predicted in issue order, which is the order the block takes them.
  function automatic grant_t queue_request(input logic [1:0] op, input logic [31:0] addr,
                                           input logic [31:0] size);
    request_t rq;
    grant_t   g;
    g.granted_address = '0;
    g.granted_bytes = '0;
    case (op)
      OP_ALLOC: begin
        g.status = model_alloc(size, g.granted_address, g.granted_bytes);
        if (g.status == ST_OK) live_pointers.push_back(g.granted_address);
      end
      OP_FREE: begin
        g.status = model_release(addr, g.granted_bytes);
        if (g.status == ST_OK)
          for (int i = live_pointers.size() - 1; i >= 0; i--)
            if (live_pointers[i] == addr) live_pointers.delete(i);
      end
      OP_ADD: g.status = model_add(addr, size, g.granted_bytes);
      default: g.status = ST_NULL;
    endcase
    g.free_bytes = mdl_free;
    g.used_bytes = mdl_used;
    g.added_bytes = mdl_added;
    rq.opcode = op;
    rq.address = addr;
    rq.size = size;
    rq.tx_idle = tx_idle_pct;
    rq.rx_idle = rx_idle_pct;
    pending_requests.push_back(rq);
    expected_grants.push_back(g);
    return g;
  endfunction

  function automatic void random_request();
    int          pick;
    int          k;
    logic [31:0] a;
    logic [31:0] s;
    grant_t      g;
    pick = $urandom_range(99);
    if (pick < 20) begin
      k = $urandom_range(9);
      if (k == 0) begin
        a = $urandom();
        s = $urandom();
      end else begin
        if (k == 1) next_base = next_base + 4 * $urandom_range(64);
        a = next_base;
        s = 4 * $urandom_range(1, 1024);
        next_base = next_base + s;
      end
      g = queue_request(OP_ADD, a, s);
    end else if (pick < 60) begin
      k = $urandom_range(19);
      if (k == 0) s = 0;
      else if (k == 1) s = $urandom();
      else s = $urandom_range(1, 600);
      g = queue_request(OP_ALLOC, $urandom(), s);
    end else if (pick < 92) begin
      k = $urandom_range(9);
      if (live_pointers.size() > 0 && k < 8)
        a = live_pointers[$urandom_range(live_pointers.size() - 1)];
      else if (k == 8) a = 0;
      else a = $urandom();
      g = queue_request(OP_FREE, a, $urandom());
    end else if (pick < 96) begin
      g = queue_request(OP_UNUSED, $urandom(), $urandom());
    end else begin
      g = queue_request(OP_ADD, $urandom(), 0);
    end
  endfunction

  always @(posedge clk) begin
    request_t rq;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (pending_requests.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
        rq = pending_requests.pop_front();
        in_tdata <= {6'b0, rq.size, rq.address, rq.opcode};
        in_tvalid <= 1'b1;
        tx_idle_pct = rq.tx_idle;
        rx_idle_pct = rq.rx_idle;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    grant_t g;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
      if (out_tvalid && out_tready) begin
        if (expected_grants.size() == 0) begin
          $error("result with no request outstanding: %h", out_tdata);
          errors++;
        end else begin
          g = expected_grants.pop_front();
          if (out_tdata[2:0] != g.status) begin
            $error("status: expected %0d, got %0d", g.status, out_tdata[2:0]);
            errors++;
          end
          if (out_tdata[34:3] != g.granted_address) begin
            $error("granted_address: expected %h, got %h", g.granted_address,
                   out_tdata[34:3]);
            errors++;
          end
          if (out_tdata[66:35] != g.granted_bytes) begin
            $error("granted_bytes: expected %h, got %h", g.granted_bytes, out_tdata[66:35]);
            errors++;
          end
          if (out_tdata[98:67] != g.free_bytes) begin
            $error("free_bytes: expected %h, got %h", g.free_bytes, out_tdata[98:67]);
            errors++;
          end
          if (out_tdata[130:99] != g.used_bytes) begin
            $error("used_bytes: expected %h, got %h", g.used_bytes, out_tdata[130:99]);
            errors++;
          end
          if (out_tdata[162:131] != g.added_bytes) begin
            $error("added_bytes: expected %h, got %h", g.added_bytes, out_tdata[162:131]);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    grant_t g;
    grant_t g2;
    for (int i = 0; i < DEPTH; i++) begin
      mdl_base[i] = '0;
      mdl_len[i] = '0;
      mdl_link[i] = 10'(i + 1);
    end
    for (int i = 0; i < BUCKETS; i++) mdl_bucket[i] = NIL;
    mdl_usable = NIL;
    mdl_spare = '0;
    mdl_free = '0;
    mdl_used = '0;
    mdl_added = '0;

    g = queue_request(OP_ALLOC, 32'h0, 32'h10);
    g = queue_request(OP_ADD, 32'h0000_1000, 32'h100);
    g = queue_request(OP_ALLOC, 32'h0, 32'h0);
    g = queue_request(OP_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    g = queue_request(OP_ALLOC, 32'h0, 32'hFFFF_FFF0);
    g = queue_request(OP_ALLOC, 32'h0, 32'h1);
    g2 = queue_request(OP_ALLOC, 32'h0, 32'h3);
    g = queue_request(OP_FREE, 32'h0, 32'h0);
    g = queue_request(OP_FREE, 32'hDEAD_BEEF, 32'h0);
    g = queue_request(OP_FREE, g.granted_address, 32'h0);
    g = queue_request(OP_FREE, g2.granted_address, 32'h0);
    g = queue_request(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    g = queue_request(OP_ADD, 32'h0000_2000, 32'h0);
    g = queue_request(OP_ADD, 32'hFFFF_FFF0, 32'h20);
    g = queue_request(OP_ALLOC, 32'h0, 32'h14);
    g = queue_request(OP_FREE, g.granted_address, 32'h0);
    g = queue_request(OP_ADD, 32'h0000_0000, 32'h80);
    g = queue_request(OP_ALLOC, 32'h0, 32'h74);
    g2 = queue_request(OP_ADD, 32'h0000_0080, 32'hFFFF_FF80);
    g2 = queue_request(OP_FREE, g.granted_address, 32'h0);
    g2 = queue_request(OP_ADD, 32'h5555_AAAC, 32'hFFFF_FFFF);

    for (int i = 0; i < 1040; i++) begin
      if (i == 350) begin
        tx_idle_pct = 69;
        rx_idle_pct = 27;
      end else if (i == 700) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      random_request();
    end
    tx_idle_pct = 27;
    rx_idle_pct = 69;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_requests.size() == 0 && expected_grants.size() == 0);
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ files.f @@
hdl/ffca_pkg.sv
hdl/ffca_ctrl.sv
hdl/ffca_dp.sv
hdl/first_fit_coalescing_allocator.sv
tb/sv/tb_first_fit_coalescing_allocator.sv
